FILE: sv/button_press_classifier_macros.svh
// Assertion macros shared by the button press classifier modules.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Condition that must hold at every clock edge.
`define BPC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bpc_pkg.sv
// Package for the button press classifier: register indices, reset values and
// the result-set structure passed from the classifier core to the emitter.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int MaxButtons     = 16;
    localparam int DefaultButtons = 4;

    localparam int CfgAddrW = 8;
    localparam int CfgDataW = 16;
    localparam int TimeW    = 32;
    localparam int BtnW     = 2;

    localparam logic [CfgAddrW-1:0] CfgDebounce  = 8'd0;
    localparam logic [CfgAddrW-1:0] CfgLongPress = 8'd1;

    localparam logic [CfgDataW-1:0] DebounceReset  = 16'd50;
    localparam logic [CfgDataW-1:0] LongPressReset = 16'd1000;

    localparam logic OpEdge = 1'b0;
    localparam logic OpTick = 1'b1;

    typedef struct packed {
        logic                  rel_valid;
        logic [BtnW-1:0]       rel_btn;
        logic                  rel_long;
        logic [MaxButtons-1:0] scan_mask;
    } bpc_res_t;

endpackage

FILE: sv/bpc_core.sv
// Classifier core: configuration registers, per-button press state and the
// combinational evaluation of one transaction. Depends on bpc_pkg.
`timescale 1ns / 1ps
`include "button_press_classifier_macros.svh"

module bpc_core #(
    parameter int BUTTONS = bpc_pkg::DefaultButtons
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bpc_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [bpc_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                          proc_en,
    input  logic                          opcode,
    input  logic [bpc_pkg::BtnW-1:0]      btn_sel,
    input  logic                          level_pressed,
    input  logic [bpc_pkg::TimeW-1:0]     time_ms,
    output bpc_pkg::bpc_res_t             res
);

    logic [bpc_pkg::CfgDataW-1:0] debounce_reg;
    logic [bpc_pkg::CfgDataW-1:0] long_lim_reg;
    logic [BUTTONS-1:0]           held_reg;
    logic [BUTTONS-1:0]           held_next;
    logic [BUTTONS-1:0]           handled_reg;
    logic [BUTTONS-1:0]           handled_next;
    logic [bpc_pkg::TimeW-1:0]    start_reg [BUTTONS];
    logic [bpc_pkg::TimeW-1:0]    start_next [BUTTONS];
    logic [bpc_pkg::TimeW-1:0]    dur [BUTTONS];
    logic [bpc_pkg::TimeW-1:0]    scan_dur [BUTTONS];
    logic [BUTTONS-1:0]           hit;
    logic [BUTTONS-1:0]           press;
    logic [BUTTONS-1:0]           release_ev;
    logic [BUTTONS-1:0]           handled_mid;
    logic [BUTTONS-1:0]           rel_hit;
    logic [BUTTONS-1:0]           rel_long_hit;
    logic [BUTTONS-1:0]           scan_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bpc_pkg::DebounceReset;
            long_lim_reg <= bpc_pkg::LongPressReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bpc_pkg::CfgDebounce:  debounce_reg <= cfg_wdata;
                bpc_pkg::CfgLongPress: long_lim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < BUTTONS; i++) begin
            hit[i]          = (opcode == bpc_pkg::OpEdge) && (int'(btn_sel) == i);
            press[i]        = hit[i] && level_pressed && !held_reg[i];
            release_ev[i]   = hit[i] && !level_pressed && held_reg[i];
            dur[i]          = time_ms - start_reg[i];
            held_next[i]    = press[i] ? 1'b1 : (release_ev[i] ? 1'b0 : held_reg[i]);
            handled_mid[i]  = press[i] ? 1'b0 : handled_reg[i];
            start_next[i]   = press[i] ? time_ms : start_reg[i];
            rel_hit[i]      = release_ev[i] && !handled_reg[i]
                              && (dur[i] >= {16'd0, debounce_reg});
            rel_long_hit[i] = rel_hit[i] && (dur[i] >= {16'd0, long_lim_reg});
            scan_dur[i]     = press[i] ? '0 : dur[i];
            scan_hit[i]     = held_next[i] && !handled_mid[i]
                              && (scan_dur[i] >= {16'd0, long_lim_reg});
            handled_next[i] = handled_mid[i] | scan_hit[i];
        end
        res           = '0;
        res.rel_valid = |rel_hit;
        res.rel_btn   = btn_sel;
        res.rel_long  = |rel_long_hit;
        res.scan_mask[BUTTONS-1:0] = scan_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            handled_reg <= '0;
        end else if (proc_en) begin
            held_reg    <= held_next;
            handled_reg <= handled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en) begin
            for (int i = 0; i < BUTTONS; i++) begin
                start_reg[i] <= start_next[i];
            end
        end
    end

    `BPC_ASSERT(a_scan_unhandled, (scan_hit & handled_mid) == '0, "scan result on handled button")
    `BPC_ASSERT(a_rel_not_scanned, !(res.rel_valid && res.scan_mask[res.rel_btn]),
                "released button also scanned")
    `BPC_ASSERT_NEXT(a_scan_marks, proc_en && (scan_hit != '0),
                     (handled_reg & $past(scan_hit)) == $past(scan_hit),
                     "scanned button not marked handled")

endmodule

FILE: sv/bpc_emit.sv
// Result emitter: holds the result set of one transaction and sends it out
// one result per cycle while m_tready is high, release result first. Depends on bpc_pkg.
`timescale 1ns / 1ps
`include "button_press_classifier_macros.svh"

module bpc_emit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  bpc_pkg::bpc_res_t        res,
    output logic                     can_load,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [bpc_pkg::BtnW-1:0] button_num,
    output logic                     is_long,
    output logic                     m_tlast
);

    logic                              rel_valid_reg;
    logic [bpc_pkg::BtnW-1:0]          rel_btn_reg;
    logic                              rel_long_reg;
    logic [bpc_pkg::MaxButtons-1:0]    mask_reg;
    logic [bpc_pkg::MaxButtons-1:0]    low_bit;
    logic [bpc_pkg::MaxButtons-1:0]    mask_rest;
    logic [$clog2(bpc_pkg::MaxButtons)-1:0] low_idx;
    logic                              fire;

    always_comb begin
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        mask_rest = mask_reg & ~low_bit;
        low_idx   = '0;
        for (int i = 0; i < bpc_pkg::MaxButtons; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | ($clog2(bpc_pkg::MaxButtons))'(i);
            end
        end
    end

    assign m_tvalid   = rel_valid_reg || (mask_reg != '0);
    assign button_num = rel_valid_reg ? rel_btn_reg : low_idx[bpc_pkg::BtnW-1:0];
    assign is_long    = rel_valid_reg ? rel_long_reg : 1'b1;
    assign m_tlast    = rel_valid_reg ? (mask_reg == '0) : (mask_rest == '0);
    assign fire       = m_tvalid && m_tready;
    assign can_load   = !m_tvalid || (fire && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else if (load) begin
            rel_valid_reg <= res.rel_valid;
            mask_reg      <= res.scan_mask;
        end else if (fire) begin
            if (rel_valid_reg) begin
                rel_valid_reg <= 1'b0;
            end else begin
                mask_reg <= mask_rest;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rel_btn_reg  <= res.rel_btn;
            rel_long_reg <= res.rel_long;
        end
    end

    `BPC_ASSERT(a_load_free, !load || can_load, "result set loaded over pending results")
    `BPC_ASSERT_NEXT(a_more_after, fire && !m_tlast && !load, m_tvalid,
                     "results lost before last")
    `BPC_ASSERT(a_count, $countones(mask_reg) + 32'(rel_valid_reg) <= 32'(bpc_pkg::MaxButtons),
                "too many pending results")

endmodule

FILE: sv/button_press_classifier.sv
// Button press classifier: an accepted input transaction passes the input register, then the
// result register, to its first result; results leave one per cycle while m_tready is high.
// A transaction with n results holds the output until all n are taken, one with none passes
// straight through, and the input register takes one more transaction meanwhile.
// Reset (aresetn low, synchronous) clears the press flags and restores the default thresholds.
`timescale 1ns / 1ps
`include "button_press_classifier_macros.svh"

module button_press_classifier #(
    parameter int BUTTONS = bpc_pkg::DefaultButtons
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bpc_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [bpc_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,  // btn_sel[1:0], level_pressed[2], time_ms[34:3]
    input  logic                         s_tuser,  // opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,  // button_num[1:0]
    output logic                         m_tuser,  // long flag
    output logic                         m_tlast
);

    logic                         in_valid_reg;
    logic                         opcode_reg;
    logic [bpc_pkg::BtnW-1:0]     btn_sel_reg;
    logic                         level_reg;
    logic [bpc_pkg::TimeW-1:0]    time_reg;
    logic                         proc_en;
    logic                         can_load;
    logic [bpc_pkg::BtnW-1:0]     button_num;
    bpc_pkg::bpc_res_t            res;

    assign proc_en  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || proc_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            opcode_reg  <= s_tuser;
            btn_sel_reg <= s_tdata[1:0];
            level_reg   <= s_tdata[2];
            time_reg    <= s_tdata[34:3];
        end
    end

    bpc_core #(
        .BUTTONS(BUTTONS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .proc_en      (proc_en),
        .opcode       (opcode_reg),
        .btn_sel      (btn_sel_reg),
        .level_pressed(level_reg),
        .time_ms      (time_reg),
        .res          (res)
    );

    bpc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (proc_en),
        .res       (res),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .button_num(button_num),
        .is_long   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {6'd0, button_num};

    `BPC_ASSERT_NEXT(a_in_hold, in_valid_reg && !proc_en, in_valid_reg,
                     "buffered transaction dropped")
    `BPC_ASSERT(a_ready_free, !in_valid_reg || !s_tready || proc_en,
                "input accepted over unprocessed transaction")
    `BPC_ASSERT_NEXT(a_proc_out, proc_en && (res.rel_valid || (res.scan_mask != '0)), m_tvalid,
                     "result set not presented")

endmodule
